// ===== hdl/bvs_pkg.sv =====
// Shared types and constants for the bitplane video shifter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bvs_pkg;

  localparam int unsigned PixelsPerGroup = 16;
  localparam int unsigned CntW = $clog2(2 * PixelsPerGroup);
  localparam logic [15:0] ColorMask = 16'h0777;

  typedef enum logic [1:0] {
    MODE_LOW     = 2'd0,
    MODE_MEDIUM  = 2'd1,
    MODE_HIGH    = 2'd2,
    MODE_LOW_ALT = 2'd3
  } mode_e;

  typedef enum logic {
    CMD_PAL_WRITE = 1'b0,
    CMD_PIXELS    = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  pal_index;
    logic [15:0] pal_value;
    logic [15:0] plane_zero;
    logic [15:0] plane_one;
    logic [15:0] plane_two;
    logic [15:0] plane_three;
  } in_t;

  typedef struct packed {
    logic [3:0] color_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       last_pixel;
  } out_t;

  // One token per cycle from the serializer unless stalled: a pixel or a palette update.
  typedef struct packed {
    logic        is_write;
    logic [3:0]  idx;
    logic [11:0] value;
    logic        last;
  } tok_t;

  // Palette lookup result: raw 3-bit channels.
  typedef struct packed {
    logic [3:0] idx;
    logic [2:0] red;
    logic [2:0] green;
    logic [2:0] blue;
    logic       last;
  } look_t;

endpackage

`default_nettype wire

// ===== hdl/bvs_serializer.sv =====
// Input stage: holds one item and turns it into one token per cycle unless stalled.
// Depends on bvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvs_serializer import bvs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire mode_e mode_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire in_t   in_data_i,
  output logic       tok_valid_o,
  input  wire logic  tok_ready_i,
  output tok_t       tok_o
);

  logic            valid_q;
  logic            cmd_q;
  mode_e           mode_q;
  logic [CntW-1:0] cnt_q;
  logic [3:0]      pidx_q;
  logic [11:0]     pval_q;
  logic [15:0]     p0_q, p1_q, p2_q, p3_q;

  logic doubled;
  logic tok_last;
  logic [3:0] pix_idx;

  assign doubled = (mode_q == MODE_LOW) || (mode_q == MODE_LOW_ALT);

  always_comb begin
    unique case (mode_q)
      MODE_HIGH:   pix_idx = {3'b000, p0_q[15]};
      MODE_MEDIUM: pix_idx = {2'b00, p1_q[15], p0_q[15]};
      default:     pix_idx = {p3_q[15], p2_q[15], p1_q[15], p0_q[15]};
    endcase
  end

  always_comb begin
    if (cmd_q == CMD_PAL_WRITE) begin
      tok_last = 1'b1;
    end else if (doubled) begin
      tok_last = (cnt_q == CntW'(2 * PixelsPerGroup - 1));
    end else begin
      tok_last = (cnt_q == CntW'(PixelsPerGroup - 1));
    end
  end

  assign in_ready_o  = !valid_q || (tok_ready_i && tok_last);
  assign tok_valid_o = valid_q;

  always_comb begin
    tok_o.is_write = (cmd_q == CMD_PAL_WRITE);
    tok_o.idx      = (cmd_q == CMD_PAL_WRITE) ? pidx_q : pix_idx;
    tok_o.value    = pval_q;
    tok_o.last     = (cmd_q == CMD_PIXELS) && tok_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
    end else if (valid_q && tok_ready_i) begin
      if (tok_last) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= in_data_i.cmd;
      mode_q <= mode_i;
      pidx_q <= in_data_i.pal_index;
      pval_q <= 12'(in_data_i.pal_value & ColorMask);
      p0_q   <= in_data_i.plane_zero;
      p1_q   <= in_data_i.plane_one;
      p2_q   <= in_data_i.plane_two;
      p3_q   <= in_data_i.plane_three;
    end else if (valid_q && tok_ready_i && (!doubled || cnt_q[0])) begin
      // advance to the next pixel; doubled mode holds each for two tokens
      p0_q <= {p0_q[14:0], 1'b0};
      p1_q <= {p1_q[14:0], 1'b0};
      p2_q <= {p2_q[14:0], 1'b0};
      p3_q <= {p3_q[14:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bvs_palette.sv =====
// Palette stage: applies palette updates in order and looks up pixel colors.
// Depends on bvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvs_palette import bvs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  tok_valid_i,
  output logic       tok_ready_o,
  input  wire tok_t  tok_i,
  output logic       look_valid_o,
  input  wire logic  look_ready_i,
  output look_t      look_o
);

  logic [11:0] pal_q [16];
  logic        valid_q;
  look_t       look_q;
  logic [11:0] entry;

  assign tok_ready_o  = !valid_q || look_ready_i;
  assign look_valid_o = valid_q;
  assign look_o       = look_q;
  assign entry        = pal_q[tok_i.idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        pal_q[i] <= '0;
      end
    end else if (tok_ready_o) begin
      // drop palette updates from the stream once stored
      valid_q <= tok_valid_i && !tok_i.is_write;
      if (tok_valid_i && tok_i.is_write) begin
        pal_q[tok_i.idx] <= tok_i.value;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_ready_o && tok_valid_i) begin
      look_q.idx   <= tok_i.idx;
      look_q.red   <= entry[10:8];
      look_q.green <= entry[6:4];
      look_q.blue  <= entry[2:0];
      look_q.last  <= tok_i.last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bvs_scale.sv =====
// Output stage: scales 3-bit channels by 36 into the output register.
// Depends on bvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvs_scale import bvs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  look_valid_i,
  output logic       look_ready_o,
  input  wire look_t look_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_t       out_data_o
);

  logic valid_q;
  out_t out_q;

  // x * 36 = x * 32 + x * 4
  function automatic logic [7:0] scale36(input logic [2:0] x);
    return {x, 5'b00000} + {3'b000, x, 2'b00};
  endfunction

  assign look_ready_o = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign out_data_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (look_ready_o) begin
      valid_q <= look_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (look_ready_o && look_valid_i) begin
      out_q.color_index <= look_i.idx;
      out_q.red_level   <= scale36(look_i.red);
      out_q.green_level <= scale36(look_i.green);
      out_q.blue_level  <= scale36(look_i.blue);
      out_q.last_pixel  <= look_i.last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bitplane_video_shifter.sv =====
// Top level of the bitplane video shifter: mode register and three stages.
// Depends on bvs_pkg, bvs_serializer, bvs_palette and bvs_scale.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes either a palette
//   write (cmd 0) or a group of four 16-bit plane words (cmd 1). Output
//   channel (out_valid_o/out_ready_i/out_data_o) gives one pixel per
//   transfer, leftmost first, with last_pixel on the final one of a group.
//   cfg_we_i/cfg_data_i write the screen mode; write it only while idle.
//   The input transfer loads the serializer; the first pixel of a group then
//   passes the palette lookup register and the scale/output register.
//   Throughput: the serializer emits one token per cycle unless stalled, so
//   a group gives 16 tokens in medium/high mode and 32 in low modes, and a
//   palette write gives one. The next item is taken in the cycle the last
//   token of the current one leaves the serializer, so groups stream
//   without gaps. Palette writes travel in order with the pixels and take
//   effect for all pixels of later groups only.
//   Reset clears the palette to zero, the mode to low, and all valid bits.
//   When the receiver stalls, each stage holds its data and back-pressure
//   reaches the input in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module bitplane_video_shifter import bvs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_t        in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_t            out_data_o
);

  mode_e screen_mode_q;
  logic  tok_valid, tok_ready;
  tok_t  tok;
  logic  look_valid, look_ready;
  look_t look;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_mode_q <= MODE_LOW;
    end else if (cfg_we_i) begin
      screen_mode_q <= mode_e'(cfg_data_i);
    end
  end

  bvs_serializer u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (screen_mode_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .tok_valid_o (tok_valid),
    .tok_ready_i (tok_ready),
    .tok_o       (tok)
  );

  bvs_palette u_pal (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (tok_valid),
    .tok_ready_o  (tok_ready),
    .tok_i        (tok),
    .look_valid_o (look_valid),
    .look_ready_i (look_ready),
    .look_o       (look)
  );

  bvs_scale u_scl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .look_valid_i (look_valid),
    .look_ready_o (look_ready),
    .look_i       (look),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hdl/bvs_checker.sv =====
// Port-level checks for the bitplane video shifter, bound to the top level.
// Depends on bvs_pkg and bitplane_video_shifter.
`timescale 1ns / 1ps
`default_nettype none

module bvs_checker import bvs_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire out_t       out_data_o
);

  // output held while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transfer dropped or changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

  // levels are multiples of 36, so their low two bits are zero
  a_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.red_level[1:0] == 2'b00) &&
                    (out_data_o.green_level[1:0] == 2'b00) &&
                    (out_data_o.blue_level[1:0] == 2'b00))
    else $error("channel level is not a scaled palette value");

  // the level never exceeds seven times 36
  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.red_level <= 8'd252) &&
                    (out_data_o.green_level <= 8'd252) &&
                    (out_data_o.blue_level <= 8'd252))
    else $error("channel level out of range");

endmodule

bind bitplane_video_shifter bvs_checker u_bvs_checker (.*);

`default_nettype wire
